>>> rtl/lbg_pkg.sv
// ----------------------------------------------------------------------------
// lbg_pkg: latency bar graph shared types and constants
// Transfer structs, operation codes, register indexes and palette colours.
// ----------------------------------------------------------------------------
package lbg_pkg;

    // default geometry
    localparam int GRAPH_WIDTH_DEF  = 48;
    localparam int GRAPH_HEIGHT_DEF = 48;

    // operation codes
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_DRAW   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic CFG_SCALE_MIN = 1'b0;
    localparam logic CFG_SCALE_MAX = 1'b1;

    // configuration reset values
    localparam logic [8:0] SCALE_MIN_RST = 9'd0;
    localparam logic [8:0] SCALE_MAX_RST = 9'd200;

    // palette colours
    localparam logic [7:0] COLOR_NORMAL = 8'hD5;
    localparam logic [7:0] COLOR_WARN   = 8'hDC;
    localparam logic [7:0] COLOR_CRIT   = 8'hF2;

    // saturated round trip
    localparam logic [29:0] RTT_MAX = 30'h3FFF_FFFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sent_time;
        logic [31:0] received_time;
        logic        command_valid;
        logic [7:0]  dropped_count;
        logic        suppressed;
    } t_in_item;

    typedef struct packed {
        logic [5:0] column;
        logic [5:0] bar_height;
        logic [7:0] color_index;
        logic       last;
    } t_out_item;

endpackage

>>> rtl/latency_bar_graph_unit.sv
// ----------------------------------------------------------------------------
// latency_bar_graph_unit: round-trip sample ring and bar graph generator
// Keeps the latest samples in a ring, tagged normal, warn or critical, and
// turns them into scaled bars, newest first, on a draw.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
//  out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//  cfg       input      i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
//  record: the item is taken, then dropped_count critical copies and the sample
//  go to the ring, one ring write port write per cycle. clear and ignored items
//  write nothing. draw: per bar, the registered ring read, then the shared
//  restoring divider, one quotient bit a cycle, unless at floor or full scale.
//  reset clears the state, write slot, fill count and output valid; ring data is
//  left as is. a stalled output holds the sequencer before the next bar only.
// ----------------------------------------------------------------------------
module latency_bar_graph_unit
    import lbg_pkg::*;
#(
    parameter int GRAPH_WIDTH  = GRAPH_WIDTH_DEF,
    parameter int GRAPH_HEIGHT = GRAPH_HEIGHT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    localparam int PW        = $clog2(GRAPH_WIDTH);
    localparam int CW        = $clog2(GRAPH_WIDTH + 1);
    localparam int QW        = $clog2(GRAPH_HEIGHT + 1);
    localparam int SW        = $clog2(QW);
    localparam int PROD_W    = 9 + QW;
    localparam int SCALE_LIM = GRAPH_HEIGHT * 10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_RD,
        S_PREP,
        S_DIV,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [8:0]    r_scale_min;
    logic [8:0]    r_scale_max;
    logic [PW-1:0] r_wr_slot;
    logic [CW-1:0] r_count;
    logic [29:0]   r_rtt;
    logic [7:0]    r_drops;
    logic          r_supp;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_left;
    logic [5:0]    r_col;
    logic [31:0]   r_rd_data;
    logic [31:0]   r_ring [GRAPH_WIDTH];
    logic [8:0]    r_rem;
    logic [QW-1:0] r_num_lo;
    logic [QW-1:0] r_quo;
    logic [SW-1:0] r_step;
    logic [7:0]    r_color;
    logic          r_out_valid;
    t_out_item     r_out_item;

    // scale limits and range
    logic [8:0]  vmin;
    logic [8:0]  vmax;
    logic        range_ok;
    logic [8:0]  range_w;

    assign vmin     = (int'(r_scale_min) > SCALE_LIM) ? 9'(SCALE_LIM) : r_scale_min;
    assign vmax     = (int'(r_scale_max) > SCALE_LIM) ? 9'(SCALE_LIM) : r_scale_max;
    assign range_ok = vmax > vmin;
    assign range_w  = vmax - vmin;

    // record item checks
    logic [31:0] rtt_full;
    logic        rec_ok;
    logic [29:0] rtt_sat;

    assign rtt_full = i_in_item.received_time - i_in_item.sent_time;
    assign rec_ok   = i_in_item.command_valid &&
                      (i_in_item.received_time >= i_in_item.sent_time);
    assign rtt_sat  = (rtt_full[31:30] != 2'b00) ? RTT_MAX : rtt_full[29:0];

    // ring write port
    logic        wr_en;
    logic [31:0] wr_data;

    assign wr_en   = (r_state == S_REC);
    assign wr_data = (r_drops != 8'd0) ? {2'b10, r_rtt} : {1'b0, r_supp, r_rtt};

    // bar preparation from the ring entry
    logic [29:0]       samp;
    logic [29:0]       diff;
    logic              at_floor;
    logic              at_full;
    logic [PROD_W-1:0] prod;
    logic [7:0]        color;

    assign samp     = r_rd_data[29:0];
    assign diff     = samp - 30'(vmin);
    assign at_floor = samp <= 30'(vmin);
    assign at_full  = diff >= 30'(range_w);
    assign prod     = PROD_W'(diff[8:0]) * PROD_W'(GRAPH_HEIGHT);
    assign color    = r_rd_data[31] ? COLOR_CRIT :
                      r_rd_data[30] ? COLOR_WARN : COLOR_NORMAL;

    // one restoring divide step
    logic [9:0] trial;
    logic [9:0] trial_sub;
    logic       q_bit;

    assign trial     = {r_rem, r_num_lo[QW-1]};
    assign trial_sub = trial - {1'b0, range_w};
    assign q_bit     = trial >= {1'b0, range_w};

    // handshakes
    logic in_xfer;
    logic out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ring memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_wr_slot] <= wr_data;
        end
        r_rd_data <= r_ring[r_rd_ptr];
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale_min <= SCALE_MIN_RST;
            r_scale_max <= SCALE_MAX_RST;
            r_wr_slot   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SCALE_MIN: r_scale_min <= i_cfg_data;
                    CFG_SCALE_MAX: r_scale_max <= i_cfg_data;
                    default: ;
                endcase
            end

            // output transfer drains the register, the emit arm reloads it
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_in_item.opcode)
                            OP_RECORD: begin
                                if (rec_ok) begin
                                    r_rtt   <= rtt_sat;
                                    r_drops <= i_in_item.dropped_count;
                                    r_supp  <= i_in_item.suppressed;
                                    r_state <= S_REC;
                                end
                            end
                            OP_CLEAR: begin
                                r_wr_slot <= '0;
                                r_count   <= '0;
                            end
                            OP_DRAW: begin
                                if (range_ok && (r_count != '0)) begin
                                    r_rd_ptr <= (r_wr_slot == '0) ?
                                                PW'(GRAPH_WIDTH - 1) : r_wr_slot - 1'b1;
                                    r_left   <= r_count;
                                    r_col    <= 6'(GRAPH_WIDTH - 1);
                                    r_state  <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                // one ring write per cycle: critical copies, then the sample
                S_REC: begin
                    r_wr_slot <= (r_wr_slot == PW'(GRAPH_WIDTH - 1)) ?
                                 '0 : r_wr_slot + 1'b1;
                    if (r_count != CW'(GRAPH_WIDTH)) begin
                        r_count <= r_count + 1'b1;
                    end
                    if (r_drops == 8'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_drops <= r_drops - 1'b1;
                    end
                end

                // registered ring read in flight
                S_RD: begin
                    r_state <= S_PREP;
                end

                // classify the sample and load the divider
                S_PREP: begin
                    r_color  <= color;
                    r_rem    <= prod[PROD_W-1:QW];
                    r_num_lo <= prod[QW-1:0];
                    r_step   <= SW'(QW - 1);
                    if (at_floor) begin
                        r_quo   <= '0;
                        r_state <= S_EMIT;
                    end else if (at_full) begin
                        r_quo   <= QW'(GRAPH_HEIGHT);
                        r_state <= S_EMIT;
                    end else begin
                        r_quo   <= '0;
                        r_state <= S_DIV;
                    end
                end

                // one quotient bit per cycle
                S_DIV: begin
                    r_rem    <= q_bit ? trial_sub[8:0] : trial[8:0];
                    r_quo    <= {r_quo[QW-2:0], q_bit};
                    r_num_lo <= r_num_lo << 1;
                    r_step   <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= S_EMIT;
                    end
                end

                // hand the bar to the output register
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out_item.column      <= r_col;
                        r_out_item.bar_height  <= 6'(r_quo);
                        r_out_item.color_index <= r_color;
                        r_out_item.last        <= (r_left == CW'(1));
                        r_left <= r_left - 1'b1;
                        r_col  <= r_col - 1'b1;
                        if (r_left == CW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_ptr <= (r_rd_ptr == '0) ?
                                        PW'(GRAPH_WIDTH - 1) : r_rd_ptr - 1'b1;
                            r_state  <= S_RD;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // fill count never passes the ring depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(GRAPH_WIDTH))
        else $error("fill count above ring depth");

    // write slot stays inside the ring
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_wr_slot) < GRAPH_WIDTH)
        else $error("write slot outside ring");

    // divider remainder stays below the range
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < range_w))
        else $error("divider remainder not below range");

    // a draw only walks a non-empty ring
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_left != '0) && (r_left <= r_count)))
        else $error("draw walking beyond stored samples");

    // a record write leaves at least one stored sample
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REC) |=> (r_count != '0))
        else $error("ring write without fill count");

endmodule
